@@ hdl/gum_pkg.sv @@
// gum_pkg: shared constants, types and the fixed 5x5 smoothing kernel
// for the gaussian unsharp mask block
// no dependencies
package gum_pkg;

	localparam int KSIZE       = 5;
	localparam int HALF        = KSIZE / 2;
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int COEF_BITS   = 16;
	localparam int STORE_DEPTH = (KSIZE - 1) * MAX_WIDTH + KSIZE;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int KIDX_W      = $clog2(KSIZE);
	localparam int TAPS        = KSIZE * KSIZE;
	localparam int TAP_W       = $clog2(TAPS);
	localparam int PIX_W       = 8;
	localparam int ACC_W       = COEF_BITS + PIX_W;
	localparam int DIM_W       = 11;
	localparam int CFG_W       = 12;
	localparam int POS_W       = 21;
	localparam int CNT_W       = 10;

	// register indexes of the configuration port
	localparam logic [1:0] REG_WIDTH     = 2'd0;
	localparam logic [1:0] REG_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;
	localparam logic [1:0] REG_GAIN      = 2'd3;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_WAIT,
		ST_CALC,
		ST_OUT
	} state_t;

	// one window tap on its way from the read address to the accumulator
	typedef struct packed {
		logic                 vld;
		logic                 in_img;
		logic                 center;
		logic [COEF_BITS-1:0] coef;
	} tap_t;

	// normalized gaussian, sigma 1.1, Q0.16, centre takes the remainder
	localparam logic [COEF_BITS-1:0] COEF_TABLE [TAPS] = '{
		16'd328,  16'd1134, 16'd1714, 16'd1134, 16'd328,
		16'd1134, 16'd3916, 16'd5920, 16'd3916, 16'd1134,
		16'd1714, 16'd5920, 16'd8952, 16'd5920, 16'd1714,
		16'd1134, 16'd3916, 16'd5920, 16'd3916, 16'd1134,
		16'd328,  16'd1134, 16'd1714, 16'd1134, 16'd328
	};

	// flipped kernel lookup for window row i, column j
	function automatic logic [COEF_BITS-1:0] coef_at(logic [KIDX_W-1:0] i,
			logic [KIDX_W-1:0] j);
		logic [TAP_W-1:0] idx;
		idx = TAP_W'(KSIZE - 1 - int'(i)) * TAP_W'(KSIZE) + TAP_W'(KSIZE - 1 - int'(j));
		return COEF_TABLE[idx];
	endfunction

	// next address in the circular row store
	function automatic addr_t addr_inc(addr_t a);
		return (a == addr_t'(STORE_DEPTH - 1)) ? '0 : addr_t'(a + 1'b1);
	endfunction

	// size register clamped to 1..limit
	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int limit);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) r = DIM_W'(1);
		if (v > DIM_W'(limit)) r = DIM_W'(limit);
		return r;
	endfunction

endpackage

@@ hdl/gaussian_unsharp_mask.sv @@
// gaussian_unsharp_mask: top level, stream counters, window sequencer and
// the threshold, gain and clipping stages; depends on gum_pkg, gum_ram, gum_filter
//
// One pixel per input transaction in raster order. Each transaction whose
// stream position yields a result goes through setup, then the window is
// fetched one tap per cycle through the single read port of the row store,
// then come pipeline drain, difference and gain stages. A transaction
// that yields no result (the first 2*width+2 of a frame) leaves the block
// idle. Results appear in raster order 2*width+2 transactions after
// their pixel; 2*width+2 flush transactions after the last pixel push out
// the final rows, and the drain field is not examined. Outside the image
// the window reads as one. Writing image_width or image_height restarts the
// frame; threshold and gain take effect at once. Configure only while idle.
module gaussian_unsharp_mask (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    pixel,
	input  logic                          drain,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_pixel,
	output logic                          out_saturated,
	output logic                          out_frame_end,
	input  logic                          cfg_wr_en,
	input  logic [1:0]                    cfg_index,
	input  logic [11:0]                   cfg_data
);

	localparam int ENH_W  = gum_pkg::ACC_W + gum_pkg::CFG_W;
	localparam int SUM_W  = ENH_W + 1;
	localparam int RES_W  = SUM_W - gum_pkg::ACC_W;

	gum_pkg::state_t                 state_q;
	gum_pkg::state_t                 state_n;

	logic [gum_pkg::DIM_W-1:0]       width_q;
	logic [gum_pkg::DIM_W-1:0]       height_q;
	logic [gum_pkg::CFG_W-1:0]       threshold_q;
	logic [gum_pkg::CFG_W-1:0]       gain_q;
	logic [gum_pkg::DIM_W-1:0]       w;
	logic [gum_pkg::DIM_W-1:0]       h;
	logic [gum_pkg::POS_W-1:0]       total;
	logic [gum_pkg::POS_W-1:0]       lat;
	logic [gum_pkg::POS_W-1:0]       total_lat;

	logic [gum_pkg::POS_W-1:0]       pos_q;
	gum_pkg::addr_t                  waddr_q;
	logic [gum_pkg::CNT_W-1:0]       orow_q;
	logic [gum_pkg::CNT_W-1:0]       ocol_q;
	gum_pkg::addr_t                  oaddr_q;

	logic [gum_pkg::CNT_W-1:0]       r_q;
	logic [gum_pkg::CNT_W-1:0]       c_q;
	gum_pkg::addr_t                  cen_q;
	logic                            fe_q;
	gum_pkg::addr_t                  rowaddr_q;
	gum_pkg::addr_t                  rdaddr_q;
	logic [gum_pkg::KIDX_W-1:0]      i_q;
	logic [gum_pkg::KIDX_W-1:0]      j_q;

	logic                            enh_q;
	logic [ENH_W-1:0]                dprod_q;
	logic                            out_valid_q;
	logic [7:0]                      out_pixel_q;
	logic                            out_sat_q;
	logic                            out_fe_q;

	logic                            in_acc;
	logic                            produce;
	logic                            write_px;
	logic                            frame_done;
	logic                            size_wr;
	logic                            read_last;
	logic                            out_load;
	logic                            filt_start;
	logic                            filt_busy;
	gum_pkg::tap_t                   tap;
	logic [gum_pkg::PIX_W-1:0]       rd_data;
	logic [gum_pkg::ACC_W-1:0]       acc;
	logic [gum_pkg::PIX_W-1:0]       pix;

	logic [gum_pkg::ADDR_W:0]        base_sum;
	logic [gum_pkg::ADDR_W:0]        row_sum;
	gum_pkg::addr_t                  base_addr;
	gum_pkg::addr_t                  row_next;
	logic [gum_pkg::DIM_W:0]         rs;
	logic [gum_pkg::DIM_W:0]         cs;
	logic [gum_pkg::ACC_W-1:0]       pq;
	logic [gum_pkg::ACC_W-1:0]       diff;
	logic [gum_pkg::ACC_W-1:0]       thr;
	logic [SUM_W-1:0]                enh_sum;
	logic [RES_W-1:0]                res;

	// effective frame geometry
	assign w         = gum_pkg::clamp_dim(width_q, gum_pkg::MAX_WIDTH);
	assign h         = gum_pkg::clamp_dim(height_q, gum_pkg::MAX_HEIGHT);
	assign total     = gum_pkg::POS_W'(w * h);
	assign lat       = gum_pkg::POS_W'({w, 1'b0}) + gum_pkg::POS_W'(2);
	assign total_lat = total + lat;

	// stream position decisions
	assign in_ready   = (state_q == gum_pkg::ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign write_px   = pos_q < total;
	assign produce    = (pos_q >= lat) && (pos_q < total_lat);
	assign frame_done = (pos_q + 1'b1) >= total_lat;
	assign size_wr    = cfg_wr_en &&
		((cfg_index == gum_pkg::REG_WIDTH) || (cfg_index == gum_pkg::REG_HEIGHT));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= gum_pkg::DIM_W'(640);
			height_q    <= gum_pkg::DIM_W'(480);
			threshold_q <= '0;
			gain_q      <= gum_pkg::CFG_W'(256);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				gum_pkg::REG_WIDTH:     width_q     <= cfg_data[gum_pkg::DIM_W-1:0];
				gum_pkg::REG_HEIGHT:    height_q    <= cfg_data[gum_pkg::DIM_W-1:0];
				gum_pkg::REG_THRESHOLD: threshold_q <= cfg_data;
				gum_pkg::REG_GAIN:      gain_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// stream counters for input and result positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			waddr_q <= '0;
			orow_q  <= '0;
			ocol_q  <= '0;
			oaddr_q <= '0;
		end else if (size_wr) begin
			pos_q   <= '0;
			waddr_q <= '0;
			orow_q  <= '0;
			ocol_q  <= '0;
			oaddr_q <= '0;
		end else if (in_acc) begin
			if (frame_done) begin
				pos_q   <= '0;
				waddr_q <= '0;
				orow_q  <= '0;
				ocol_q  <= '0;
				oaddr_q <= '0;
			end else begin
				pos_q   <= pos_q + 1'b1;
				waddr_q <= gum_pkg::addr_inc(waddr_q);
				if (produce) begin
					oaddr_q <= gum_pkg::addr_inc(oaddr_q);
					if (gum_pkg::DIM_W'(ocol_q) == w - 1'b1) begin
						ocol_q <= '0;
						orow_q <= orow_q + 1'b1;
					end else begin
						ocol_q <= ocol_q + 1'b1;
					end
				end
			end
		end
	end

	// first tap address: centre minus two rows and two columns, modulo depth
	assign base_sum  = {1'b0, cen_q} + (gum_pkg::ADDR_W+1)'(gum_pkg::STORE_DEPTH - 2)
		- (gum_pkg::ADDR_W+1)'({w, 1'b0});
	assign base_addr = (base_sum >= (gum_pkg::ADDR_W+1)'(gum_pkg::STORE_DEPTH)) ?
		gum_pkg::ADDR_W'(base_sum - (gum_pkg::ADDR_W+1)'(gum_pkg::STORE_DEPTH)) :
		gum_pkg::ADDR_W'(base_sum);
	assign row_sum   = {1'b0, rowaddr_q} + (gum_pkg::ADDR_W+1)'(w);
	assign row_next  = (row_sum >= (gum_pkg::ADDR_W+1)'(gum_pkg::STORE_DEPTH)) ?
		gum_pkg::ADDR_W'(row_sum - (gum_pkg::ADDR_W+1)'(gum_pkg::STORE_DEPTH)) :
		gum_pkg::ADDR_W'(row_sum);
	assign read_last = (i_q == gum_pkg::KIDX_W'(gum_pkg::KSIZE - 1)) &&
		(j_q == gum_pkg::KIDX_W'(gum_pkg::KSIZE - 1));

	// tap inside the image
	assign rs  = (gum_pkg::DIM_W+1)'(r_q) + (gum_pkg::DIM_W+1)'(i_q);
	assign cs  = (gum_pkg::DIM_W+1)'(c_q) + (gum_pkg::DIM_W+1)'(j_q);
	assign tap.vld    = (state_q == gum_pkg::ST_READ);
	assign tap.in_img = (rs >= (gum_pkg::DIM_W+1)'(gum_pkg::HALF)) &&
		(rs < (gum_pkg::DIM_W+1)'(h) + (gum_pkg::DIM_W+1)'(gum_pkg::HALF)) &&
		(cs >= (gum_pkg::DIM_W+1)'(gum_pkg::HALF)) &&
		(cs < (gum_pkg::DIM_W+1)'(w) + (gum_pkg::DIM_W+1)'(gum_pkg::HALF));
	assign tap.center = (i_q == gum_pkg::KIDX_W'(gum_pkg::HALF)) &&
		(j_q == gum_pkg::KIDX_W'(gum_pkg::HALF));
	assign tap.coef   = gum_pkg::coef_at(i_q, j_q);
	assign filt_start = (state_q == gum_pkg::ST_SETUP);

	// window sequencer registers
	always_ff @(posedge clk) begin
		if (in_acc && produce) begin
			r_q   <= orow_q;
			c_q   <= ocol_q;
			cen_q <= oaddr_q;
			fe_q  <= (gum_pkg::DIM_W'(ocol_q) == w - 1'b1) &&
				(gum_pkg::DIM_W'(orow_q) == h - 1'b1);
		end
		if (state_q == gum_pkg::ST_SETUP) begin
			rowaddr_q <= base_addr;
			rdaddr_q  <= base_addr;
			i_q       <= '0;
			j_q       <= '0;
		end else if (state_q == gum_pkg::ST_READ) begin
			if (j_q == gum_pkg::KIDX_W'(gum_pkg::KSIZE - 1)) begin
				rowaddr_q <= row_next;
				rdaddr_q  <= row_next;
				j_q       <= '0;
				i_q       <= i_q + 1'b1;
			end else begin
				rdaddr_q <= gum_pkg::addr_inc(rdaddr_q);
				j_q      <= j_q + 1'b1;
			end
		end
	end

	// row store
	gum_ram #(
		.WIDTH(gum_pkg::PIX_W),
		.DEPTH(gum_pkg::STORE_DEPTH)
	) u_row_store (
		.clk    (clk),
		.wr_en  (in_acc && write_px),
		.wr_addr(waddr_q),
		.wr_data(pixel),
		.rd_addr(rdaddr_q),
		.rd_data(rd_data)
	);

	// window multiply-accumulate
	gum_filter u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (filt_start),
		.tap    (tap),
		.rd_data(rd_data),
		.acc    (acc),
		.pix    (pix),
		.busy   (filt_busy)
	);

	// difference, threshold test and gain product
	assign pq   = {pix, gum_pkg::COEF_BITS'(0)};
	assign diff = pq - acc;
	assign thr  = gum_pkg::ACC_W'({threshold_q, 12'd0});

	always_ff @(posedge clk) begin
		if (state_q == gum_pkg::ST_CALC) begin
			enh_q   <= (pq > acc) && (diff > thr);
			dprod_q <= ENH_W'(diff * gain_q);
		end
	end

	// rounding and clipping
	assign enh_sum = SUM_W'({pix, gum_pkg::ACC_W'(0)}) + SUM_W'(dprod_q)
		+ SUM_W'(1 << (gum_pkg::ACC_W - 1));
	assign res     = enh_sum[SUM_W-1:gum_pkg::ACC_W];
	assign out_load = (state_q == gum_pkg::ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_fe_q <= fe_q;
			if (!enh_q) begin
				out_pixel_q <= pix;
				out_sat_q   <= 1'b0;
			end else if (res > RES_W'(255)) begin
				out_pixel_q <= 8'hFF;
				out_sat_q   <= 1'b1;
			end else begin
				out_pixel_q <= res[7:0];
				out_sat_q   <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_pixel     = out_pixel_q;
	assign out_saturated = out_sat_q;
	assign out_frame_end = out_fe_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gum_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			gum_pkg::ST_IDLE:  if (in_acc && produce) state_n = gum_pkg::ST_SETUP;
			gum_pkg::ST_SETUP: state_n = gum_pkg::ST_READ;
			gum_pkg::ST_READ:  if (read_last) state_n = gum_pkg::ST_WAIT;
			gum_pkg::ST_WAIT:  if (!filt_busy) state_n = gum_pkg::ST_CALC;
			gum_pkg::ST_CALC:  state_n = gum_pkg::ST_OUT;
			gum_pkg::ST_OUT:   if (out_load) state_n = gum_pkg::ST_IDLE;
			default:           state_n = gum_pkg::ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	// clipping always reports full scale
	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_saturated |-> out_pixel == 8'hFF)
		else $error("saturated result not at full scale");

	// write pointer stays within the row store
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		waddr_q < gum_pkg::addr_t'(gum_pkg::STORE_DEPTH))
		else $error("row store write address out of range");

	// window counters stay within the kernel while fetching
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gum_pkg::ST_READ |->
		i_q < gum_pkg::KIDX_W'(gum_pkg::KSIZE) && j_q < gum_pkg::KIDX_W'(gum_pkg::KSIZE))
		else $error("window tap counter out of range");

	// no tap is in flight once the difference stage runs
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gum_pkg::ST_CALC |-> !filt_busy)
		else $error("accumulator not drained before difference stage");

	// input is refused while a window is being processed
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gum_pkg::ST_READ |=> !(in_valid && in_ready) || state_q == gum_pkg::ST_IDLE)
		else $error("transaction accepted during window fetch");
`endif

endmodule

@@ hdl/gum_ram.sv @@
// gum_ram: generic single write port, single read port ram with registered read
// no dependencies
module gum_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ hdl/gum_filter.sv @@
// gum_filter: multiply-accumulate of window taps read from the row store
// depends on gum_pkg
module gum_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  gum_pkg::tap_t                      tap,
	input  logic [gum_pkg::PIX_W-1:0]          rd_data,
	output logic [gum_pkg::ACC_W-1:0]          acc,
	output logic [gum_pkg::PIX_W-1:0]          pix,
	output logic                               busy
);

	logic                            vld_s1;
	logic                            inside_s1;
	logic                            center_s1;
	logic [gum_pkg::COEF_BITS-1:0]   coef_s1;
	logic                            vld_s2;
	logic [gum_pkg::ACC_W-1:0]       prod_s2;
	logic [gum_pkg::ACC_W-1:0]       acc_q;
	logic [gum_pkg::PIX_W-1:0]       pix_q;
	logic [gum_pkg::PIX_W-1:0]       tap_val;

	// outside taps read as one
	assign tap_val = inside_s1 ? rd_data : gum_pkg::PIX_W'(1);

	// valid flags follow the read latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= tap.vld;
			vld_s2 <= vld_s1;
		end
	end

	// tap attributes, product and centre pixel
	always_ff @(posedge clk) begin
		inside_s1 <= tap.in_img;
		center_s1 <= tap.center;
		coef_s1   <= tap.coef;
		prod_s2   <= gum_pkg::ACC_W'(coef_s1 * tap_val);
		if (vld_s1 && center_s1) begin
			pix_q <= rd_data;
		end
	end

	// accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign acc  = acc_q;
	assign pix  = pix_q;
	assign busy = vld_s1 | vld_s2;

endmodule
